>>> src/drr_pkg.sv
// Shared types and constants for the decimal rescale-and-round core.
// Depends on nothing; the interface file and the core import it.
package drr_pkg;

    localparam int FIELD_BITS = 64;
    localparam int FULL_BITS  = 3 * FIELD_BITS;
    localparam int SCALE_BITS = 8;

    // Scaling limits of the fit-to-96-bits mode
    localparam int                    WIDE_BITS = 96;
    localparam logic [SCALE_BITS-1:0] MAX_SCALE = 8'd28;

    // Decimal digit handling
    localparam int        REM_BITS   = 4;
    localparam logic [REM_BITS-1:0] HALF_DIGIT = 4'd5;

    // Divide-by-ten step: one chunk of the mantissa per cycle
    localparam int          CHUNK_BITS   = 16;
    localparam int          DIVIN_BITS   = REM_BITS + CHUNK_BITS;
    localparam int          MAGIC_BITS   = 32;
    localparam int          PROD_BITS    = DIVIN_BITS + MAGIC_BITS;
    localparam logic [MAGIC_BITS-1:0] DIV10_MAGIC = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT  = 35;

    // Mode codes
    localparam logic MODE_FIT = 1'b0;
    localparam logic MODE_INT = 1'b1;

    // Rounding codes
    localparam logic [1:0] RT_FLOOR     = 2'd0;
    localparam logic [1:0] RT_HALF_EVEN = 2'd1;
    localparam logic [1:0] RT_HALF_UP   = 2'd2;

    typedef struct packed {
        logic                  mode;
        logic [1:0]            round_type;
        logic [FIELD_BITS-1:0] mant_low;
        logic [FIELD_BITS-1:0] mant_mid;
        logic [FIELD_BITS-1:0] mant_high;
        logic [SCALE_BITS-1:0] scale;
        logic                  negative;
    } drr_in_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] res_low;
        logic [FIELD_BITS-1:0] res_mid;
        logic [FIELD_BITS-1:0] res_high;
        logic [SCALE_BITS-1:0] res_scale;
        logic                  res_negative;
    } drr_out_t;

endpackage

>>> src/drr_if.sv
// Valid/ready channel interfaces for the input and result items.
// Depends on drr_pkg for the payload types.
interface drr_in_if;
    import drr_pkg::*;

    logic    valid;
    logic    ready;
    drr_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface drr_out_if;
    import drr_pkg::*;

    logic     valid;
    logic     ready;
    drr_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/decimal_rescale_round_core.sv
// Decimal rescale-and-round core: repeated divide-by-ten, then rounding.
// Depends on drr_pkg and the channel interfaces in drr_if.sv.
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+-------------------------------------------
//  in_ch    | in  | valid/ready         | mode, round_type, mant_*, scale, negative
//  out_ch   | out | valid/ready         | res_low/mid/high, res_scale, res_negative
//
// Each divide-by-ten pass runs the single 20-bit divide-by-ten unit over the mantissa,
// one 16-bit chunk per cycle (NCH = MANT_BITS/16 rounded up chunks, 12 at the default
// width), after a check state. The result is written when the output register is free;
// the input turns ready on the same edge as the result shows.
// Reset clears the sequencer and the result valid; no clearing pass is needed.
// The input side is ready only when the sequencer is idle; a finished result waits
// in the output register, and the next item may be accepted meanwhile.
module decimal_rescale_round_core #(
    parameter int MANT_BITS = 192
) (
    input  logic             clk,
    input  logic             rst_n,
    drr_in_if.sink           in_ch,
    drr_out_if.source        out_ch
);
    import drr_pkg::*;

    localparam int NCH      = (MANT_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int PAD_BITS = NCH * CHUNK_BITS;
    localparam int CNT_W    = $clog2(NCH);
    localparam logic [CNT_W-1:0]    LAST_CHUNK = CNT_W'(NCH - 1);
    localparam logic [PAD_BITS-1:0] MANT_MASK  = PAD_BITS'({MANT_BITS{1'b1}});

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_ROUND = 2'd3;

    // Control registers
    logic [1:0]       state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    // Working registers (no reset needed)
    logic                  mode_reg, mode_next;
    logic [1:0]            rtype_reg, rtype_next;
    logic                  neg_reg, neg_next;
    logic [SCALE_BITS-1:0] scale_reg, scale_next;
    logic [PAD_BITS-1:0]   mant_reg, mant_next;
    logic [REM_BITS-1:0]   rem_reg, rem_next;
    logic [REM_BITS-1:0]   last_reg, last_next;
    logic                  sticky_reg, sticky_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    drr_out_t              out_data_reg, out_data_next;

    // Divide-by-ten unit: top chunk of the mantissa with the running remainder
    logic [DIVIN_BITS-1:0] div_in;
    logic [PROD_BITS-1:0]  div_prod;
    logic [CHUNK_BITS-1:0] div_q;
    logic [DIVIN_BITS-1:0] div_back;
    logic [DIVIN_BITS-1:0] div_diff;
    logic [REM_BITS-1:0]   div_r;

    // Pass decision and rounding
    logic                  is_wide;
    logic                  is_zero;
    logic                  do_pass;
    logic [1:0]            eff_rtype;
    logic                  round_up;
    logic [PAD_BITS-1:0]   mant_rounded;
    logic [FULL_BITS-1:0]  res_full;
    logic [FULL_BITS-1:0]  in_full;
    logic                  out_free;

    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    // Quotient by reciprocal multiply; remainder from q * 10 by shift-add
    assign div_in   = {rem_reg, mant_reg[PAD_BITS-1 -: CHUNK_BITS]};
    assign div_prod = PROD_BITS'(div_in) * PROD_BITS'(DIV10_MAGIC);
    assign div_q    = div_prod[DIV10_SHIFT +: CHUNK_BITS];
    assign div_back = (DIVIN_BITS'(div_q) << 3) + (DIVIN_BITS'(div_q) << 1);
    assign div_diff = div_in - div_back;
    assign div_r    = div_diff[REM_BITS-1:0];

    assign is_wide = |mant_reg[PAD_BITS-1:WIDE_BITS];
    assign is_zero = (mant_reg == '0);

    // Keep dividing while the loop condition of the selected mode holds
    always_comb
    begin
        if (mode_reg == MODE_FIT)
        begin
            do_pass = (is_wide && (scale_reg != '0)) || (scale_reg > MAX_SCALE);
        end
        else
        begin
            do_pass = (scale_reg != '0) && !is_zero;
        end
    end

    // Fit mode always rounds half to even
    assign eff_rtype = (mode_reg == MODE_FIT) ? RT_HALF_EVEN : rtype_reg;

    always_comb
    begin
        case (eff_rtype)
            RT_FLOOR:
            begin
                round_up = neg_reg && ((last_reg != '0) || sticky_reg);
            end
            RT_HALF_EVEN:
            begin
                if ((last_reg == HALF_DIGIT) && !sticky_reg)
                begin
                    round_up = mant_reg[0];
                end
                else
                begin
                    round_up = (last_reg >= HALF_DIGIT);
                end
            end
            RT_HALF_UP:
            begin
                round_up = (last_reg >= HALF_DIGIT);
            end
            default:
            begin
                round_up = 1'b0;
            end
        endcase
    end

    // Increment wraps within the mantissa width
    assign mant_rounded = round_up ? ((mant_reg + PAD_BITS'(1)) & MANT_MASK) : mant_reg;
    assign res_full     = FULL_BITS'(mant_rounded);
    assign in_full      = {in_ch.data.mant_high, in_ch.data.mant_mid, in_ch.data.mant_low};
    assign out_free     = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        mode_next      = mode_reg;
        rtype_next     = rtype_reg;
        neg_next       = neg_reg;
        scale_next     = scale_reg;
        mant_next      = mant_reg;
        rem_next       = rem_reg;
        last_next      = last_reg;
        sticky_next    = sticky_reg;
        cnt_next       = cnt_reg;
        out_data_next  = out_data_reg;

        // Drop the result once taken
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    mode_next   = in_ch.data.mode;
                    rtype_next  = in_ch.data.round_type;
                    neg_next    = in_ch.data.negative;
                    scale_next  = in_ch.data.scale;
                    mant_next   = PAD_BITS'(in_full[MANT_BITS-1:0]);
                    last_next   = '0;
                    sticky_next = 1'b0;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (do_pass)
                begin
                    // Fold the previous digit into sticky, start a new pass
                    if (last_reg != '0)
                    begin
                        sticky_next = 1'b1;
                    end
                    rem_next   = '0;
                    cnt_next   = LAST_CHUNK;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_DIV:
            begin
                // Rotate the quotient chunk in at the bottom
                mant_next = {mant_reg[PAD_BITS-CHUNK_BITS-1:0], div_q};
                rem_next  = div_r;
                if (cnt_reg == '0)
                begin
                    last_next  = div_r;
                    scale_next = scale_reg - SCALE_BITS'(1);
                    state_next = ST_CHECK;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_ROUND:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    out_data_next.res_low      = res_full[FIELD_BITS-1:0];
                    out_data_next.res_mid      = res_full[2*FIELD_BITS-1:FIELD_BITS];
                    out_data_next.res_high     = res_full[FULL_BITS-1:2*FIELD_BITS];
                    out_data_next.res_scale    = scale_reg;
                    out_data_next.res_negative = neg_reg;
                    out_valid_next             = 1'b1;
                    state_next                 = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        rtype_reg    <= rtype_next;
        neg_reg      <= neg_next;
        scale_reg    <= scale_next;
        mant_reg     <= mant_next;
        rem_reg      <= rem_next;
        last_reg     <= last_next;
        sticky_reg   <= sticky_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
    end

endmodule

>>> dv/tb_decimal_rescale_round_core.sv
// Self-checking testbench for decimal_rescale_round_core.
// Drives items through drr_in_if, checks results from drr_out_if against a predictor.
// Depends on drr_pkg, drr_if.sv and the core itself.
`timescale 1ns / 1ps

module tb_decimal_rescale_round_core;
    import drr_pkg::*;

    // Mantissa width of the block under test; the predictor masks to it.
    localparam int MANT_BITS = 192;
    localparam logic [FULL_BITS-1:0] MANT_MASK = {FULL_BITS{1'b1}} >> (FULL_BITS - MANT_BITS);
    localparam logic [FULL_BITS-1:0] ALL_ONES  = {FULL_BITS{1'b1}};
    localparam logic [FULL_BITS-1:0] TWO_POW_WIDE = FULL_BITS'(1) << WIDE_BITS;

    // Round code with no rule behind it: mode int truncates.
    localparam logic [1:0] RT_UNUSED = 2'd3;

    // Worst item is about 255 passes; the stall limit leaves room for it and the long hold-off.
    localparam int STALL_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_PER_PROFILE = 100;

    typedef struct {
        drr_in_t  stim;
        bit       typed;
        drr_out_t want;
    } directed_row_t;

    logic clk;
    logic rst_n;

    drr_in_if  in_ch ();
    drr_out_if out_ch ();

    decimal_rescale_round_core #(
        .MANT_BITS (MANT_BITS)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Results still owed by the block, oldest first
    drr_out_t pending_results[$];
    directed_row_t directed_rows[$];

    int mismatches     = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int fit_items      = 0;
    int int_items      = 0;
    int max_scale_sent = 0;

    // Idle profile for the sender task and the receiver process, and the watchdog count
    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    // Free-running clock, 20 ns period
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Predictor: divide by ten while the mode's loop condition holds, keeping the
    // last digit and a sticky mark for any earlier nonzero digit, then round by
    // adding one to the magnitude. The sign never changes.
    function automatic drr_out_t rescale_round(input drr_in_t it);
        logic [FULL_BITS-1:0] mag;
        int unsigned          sc;
        logic [REM_BITS-1:0]  last_digit;
        logic                 sticky;
        logic                 bump;
        logic [1:0]           rule;
        drr_out_t             res;
        mag        = {it.mant_high, it.mant_mid, it.mant_low} & MANT_MASK;
        sc         = it.scale;
        last_digit = '0;
        sticky     = 1'b0;
        rule       = it.round_type;
        if (it.mode == MODE_FIT)
        begin
            // Fit to 96 bits and at most 28 digits of fraction; always half-even
            while ((((mag >> WIDE_BITS) != 0) && sc > 0) || sc > MAX_SCALE)
            begin
                sticky     = sticky | (last_digit != 0);
                last_digit = REM_BITS'(mag % 10);
                mag        = mag / 10;
                sc--;
            end
            rule = RT_HALF_EVEN;
        end
        else
        begin
            // Scale to an integer, stopping early once the magnitude is zero
            while (sc > 0 && mag != 0)
            begin
                sticky     = sticky | (last_digit != 0);
                last_digit = REM_BITS'(mag % 10);
                mag        = mag / 10;
                sc--;
            end
        end
        case (rule)
            RT_FLOOR:     bump = it.negative && (last_digit != 0 || sticky);
            RT_HALF_EVEN: bump = (last_digit == HALF_DIGIT && !sticky) ? mag[0]
                                                                     : (last_digit >= HALF_DIGIT);
            RT_HALF_UP:   bump = (last_digit >= HALF_DIGIT);
            default:      bump = 1'b0;
        endcase
        if (bump)
            mag = (mag + 1) & MANT_MASK;
        res.res_low      = mag[FIELD_BITS-1:0];
        res.res_mid      = mag[2*FIELD_BITS-1:FIELD_BITS];
        res.res_high     = mag[FULL_BITS-1:2*FIELD_BITS];
        res.res_scale    = SCALE_BITS'(sc);
        res.res_negative = it.negative;
        return res;
    endfunction

    function automatic drr_in_t stim(input logic mode, input logic [1:0] rt,
                                     input logic [FULL_BITS-1:0] mant,
                                     input logic [SCALE_BITS-1:0] sc, input logic neg);
        drr_in_t it;
        it.mode       = mode;
        it.round_type = rt;
        it.mant_low   = mant[FIELD_BITS-1:0];
        it.mant_mid   = mant[2*FIELD_BITS-1:FIELD_BITS];
        it.mant_high  = mant[FULL_BITS-1:2*FIELD_BITS];
        it.scale      = sc;
        it.negative   = neg;
        return it;
    endfunction

    function automatic drr_out_t want(input logic [FULL_BITS-1:0] mant,
                                      input logic [SCALE_BITS-1:0] sc, input logic neg);
        drr_out_t res;
        res.res_low      = mant[FIELD_BITS-1:0];
        res.res_mid      = mant[2*FIELD_BITS-1:FIELD_BITS];
        res.res_high     = mant[FULL_BITS-1:2*FIELD_BITS];
        res.res_scale    = sc;
        res.res_negative = neg;
        return res;
    endfunction

    // Offer one item and hold it until accepted; then maybe go idle for a while.
    // Called only at a rising edge, so valid is never dropped and raised in one step.
    task automatic send_item(input drr_in_t it, input drr_out_t typed_res, input bit typed);
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        pending_results.push_back(typed ? typed_res : rescale_round(it));
        items_sent++;
        if (it.mode == MODE_FIT)
            fit_items++;
        else
            int_items++;
        if (it.scale > max_scale_sent)
            max_scale_sent = it.scale;
        if ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < in_idle_pct);
        end
    endtask

    // Stop offering and wait for every owed result; always advances at least one edge
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    // Random items: mostly modest scales, a few deep ones; mantissas small, near the
    // 96-bit boundary, randomly shifted, full width, or built to land on an exact half.
    task automatic run_random(input int count);
        drr_in_t              it;
        logic [FULL_BITS-1:0] full;
        logic [FULL_BITS-1:0] mag;
        logic [FULL_BITS-1:0] pow;
        int                   pick;
        int                   digits;
        int                   dice;
        for (int n = 0; n < count; n++)
        begin
            it.mode       = $urandom_range(0, 1);
            it.round_type = $urandom_range(0, 3);
            it.negative   = $urandom_range(0, 1);
            full = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            pick = $urandom_range(0, 99);
            dice = $urandom_range(0, 99);
            if (dice < 75)
                it.scale = $urandom_range(0, 40);
            else if (dice < 95)
                it.scale = $urandom_range(41, 90);
            else
                it.scale = $urandom_range(91, 255);
            if (pick < 25)
                mag = FULL_BITS'($urandom);
            else if (pick < 40)
                mag = full >> $urandom_range(90, 100);
            else if (pick < 55)
                mag = full >> $urandom_range(0, 150);
            else if (pick < 70)
                mag = full;
            else
            begin
                // Exact half on the last digit, sometimes with a sticky digit below it
                digits = $urandom_range(1, 3);
                pow = 1;
                repeat (digits) pow = pow * 10;
                mag = (full >> $urandom_range(100, 190)) * pow + 5 * (pow / 10);
                if ($urandom_range(0, 3) == 0)
                    mag = mag + 1;
                it.scale = (it.mode == MODE_FIT) ? MAX_SCALE + digits : SCALE_BITS'(digits);
            end
            it.mant_low  = mag[FIELD_BITS-1:0];
            it.mant_mid  = mag[2*FIELD_BITS-1:FIELD_BITS];
            it.mant_high = mag[FULL_BITS-1:2*FIELD_BITS];
            send_item(it, '0, 1'b0);
        end
    endtask

    // Receiver: random stalls per the profile, plus a long hold-off on request.
    // Hold the result channel low for the whole hold-off so the core backs up.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (hold_left == 0 && hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(0, 99) >= out_stall_pct);
        end
    end

    // Result checker: compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin : check_results
        drr_out_t exp_r;
        drr_out_t got;
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            got = out_ch.data;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result with no item outstanding: %h", got);
                mismatches++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (got.res_low !== exp_r.res_low)
                begin
                    $error("res_low: expected %h, got %h", exp_r.res_low, got.res_low);
                    mismatches++;
                end
                if (got.res_mid !== exp_r.res_mid)
                begin
                    $error("res_mid: expected %h, got %h", exp_r.res_mid, got.res_mid);
                    mismatches++;
                end
                if (got.res_high !== exp_r.res_high)
                begin
                    $error("res_high: expected %h, got %h", exp_r.res_high, got.res_high);
                    mismatches++;
                end
                if (got.res_scale !== exp_r.res_scale)
                begin
                    $error("res_scale: expected %0d, got %0d", exp_r.res_scale, got.res_scale);
                    mismatches++;
                end
                if (got.res_negative !== exp_r.res_negative)
                begin
                    $error("res_negative: expected %b, got %b",
                           exp_r.res_negative, got.res_negative);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: count edges where neither channel moves an item
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog: no item moved for %0d cycles, %0d results owed",
                         quiet_cycles, pending_results.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Main sequence: reset, directed table, four idle profiles of random items
    initial
    begin
        int idle_in_profile[4];
        int stall_out_profile[4];
        idle_in_profile   = '{0, 73, 0, 27};
        stall_out_profile = '{0, 0, 73, 27};

        rst_n       <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;

        // Directed table; typed results only where they are plain to see
        // Zero in, zero out
        directed_rows.push_back('{stim(MODE_INT, RT_FLOOR, '0, 8'd0, 1'b0), 1'b1,
                                  want('0, 8'd0, 1'b0)});
        // Too wide but no exponent left: reported as is
        directed_rows.push_back('{stim(MODE_FIT, RT_HALF_EVEN, ALL_ONES, 8'd0, 1'b0), 1'b1,
                                  want(ALL_ONES & MANT_MASK, 8'd0, 1'b0)});
        // Deepest scaling in both modes
        directed_rows.push_back('{stim(MODE_FIT, RT_FLOOR, ALL_ONES, 8'd255, 1'b1), 1'b0, '0});
        directed_rows.push_back('{stim(MODE_INT, RT_FLOOR, ALL_ONES, 8'd255, 1'b1), 1'b0, '0});
        // Half-even: exact half to even quotient, to odd quotient, half with sticky
        directed_rows.push_back('{stim(MODE_INT, RT_HALF_EVEN, 25, 8'd1, 1'b0), 1'b1,
                                  want(2, 8'd0, 1'b0)});
        directed_rows.push_back('{stim(MODE_INT, RT_HALF_EVEN, 35, 8'd1, 1'b0), 1'b1,
                                  want(4, 8'd0, 1'b0)});
        directed_rows.push_back('{stim(MODE_INT, RT_HALF_EVEN, 251, 8'd2, 1'b0), 1'b1,
                                  want(3, 8'd0, 1'b0)});
        // Half-up on and just below the half
        directed_rows.push_back('{stim(MODE_INT, RT_HALF_UP, 25, 8'd1, 1'b0), 1'b1,
                                  want(3, 8'd0, 1'b0)});
        directed_rows.push_back('{stim(MODE_INT, RT_HALF_UP, 24, 8'd1, 1'b0), 1'b1,
                                  want(2, 8'd0, 1'b0)});
        // Floor: positive truncates, negative steps away on last digit or sticky
        directed_rows.push_back('{stim(MODE_INT, RT_FLOOR, 29, 8'd1, 1'b0), 1'b1,
                                  want(2, 8'd0, 1'b0)});
        directed_rows.push_back('{stim(MODE_INT, RT_FLOOR, 29, 8'd1, 1'b1), 1'b1,
                                  want(3, 8'd0, 1'b1)});
        directed_rows.push_back('{stim(MODE_INT, RT_FLOOR, 201, 8'd2, 1'b1), 1'b1,
                                  want(3, 8'd0, 1'b1)});
        // Unused round code truncates
        directed_rows.push_back('{stim(MODE_INT, RT_UNUSED, 29, 8'd1, 1'b0), 1'b1,
                                  want(2, 8'd0, 1'b0)});
        // Integer mode stops early at zero
        directed_rows.push_back('{stim(MODE_INT, RT_HALF_EVEN, 0, 8'd5, 1'b0), 1'b1,
                                  want(0, 8'd5, 1'b0)});
        directed_rows.push_back('{stim(MODE_INT, RT_HALF_EVEN, 7, 8'd5, 1'b0), 1'b1,
                                  want(1, 8'd4, 1'b0)});
        // Fit mode: exponent above 28 forces passes; round code is ignored
        directed_rows.push_back('{stim(MODE_FIT, RT_HALF_EVEN, 123456789, 8'd30, 1'b0), 1'b1,
                                  want(1234568, MAX_SCALE, 1'b0)});
        directed_rows.push_back('{stim(MODE_FIT, RT_FLOOR, 123456789, 8'd30, 1'b1), 1'b1,
                                  want(1234568, MAX_SCALE, 1'b1)});
        directed_rows.push_back('{stim(MODE_FIT, RT_HALF_UP, 45, 8'd29, 1'b1), 1'b1,
                                  want(4, MAX_SCALE, 1'b1)});
        // 96-bit boundary: just over, just under, and a half on top of it
        directed_rows.push_back('{stim(MODE_FIT, RT_HALF_EVEN, TWO_POW_WIDE, 8'd3, 1'b0),
                                  1'b0, '0});
        directed_rows.push_back('{stim(MODE_FIT, RT_HALF_EVEN, TWO_POW_WIDE - 1, MAX_SCALE,
                                       1'b0), 1'b1, want(TWO_POW_WIDE - 1, MAX_SCALE, 1'b0)});
        directed_rows.push_back('{stim(MODE_FIT, RT_HALF_EVEN, TWO_POW_WIDE * 10 + 5, 8'd1,
                                       1'b0), 1'b0, '0});
        // Rounding carries out of bit 95
        directed_rows.push_back('{stim(MODE_INT, RT_HALF_UP, (TWO_POW_WIDE - 1) * 10 + 5,
                                       8'd1, 1'b0), 1'b1, want(TWO_POW_WIDE, 8'd0, 1'b0)});
        // Integer already, full width passes through; then a high mantissa scaled by 60
        directed_rows.push_back('{stim(MODE_INT, RT_HALF_EVEN, ALL_ONES, 8'd0, 1'b1), 1'b1,
                                  want(ALL_ONES & MANT_MASK, 8'd0, 1'b1)});
        directed_rows.push_back('{stim(MODE_INT, RT_HALF_UP, {64'hFFFF_FFFF_FFFF_FFFF, 128'd0},
                                       8'd60, 1'b0), 1'b0, '0});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part runs with no idling on either side
        foreach (directed_rows[i])
            send_item(directed_rows[i].stim, directed_rows[i].want, directed_rows[i].typed);
        drain_results();

        for (int p = 0; p < 4; p++)
        begin
            in_idle_pct   = idle_in_profile[p];
            out_stall_pct = stall_out_profile[p];
            // First profile opens with a long receiver hold-off while items keep coming
            if (p == 0)
                hold_request = HOLD_CYCLES;
            run_random(RANDOM_PER_PROFILE);
            // Pause the sender until every owed result is back
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Summary: %0d items (%0d directed, %0d fit, %0d integer), %0d results checked",
                 items_sent, directed_rows.size(), fit_items, int_items, results_seen);
        $display("Summary: four idle profiles, one %0d-cycle receiver hold-off, scales to %0d",
                 HOLD_CYCLES, max_scale_sent);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> files.f
src/drr_pkg.sv
src/drr_if.sv
src/decimal_rescale_round_core.sv
dv/tb_decimal_rescale_round_core.sv
